>>> src/pdmx_pkg.sv
// Package for the per-database minimum xid tracker.
// Holds the slot entry type, the result status codes and the report kind codes.
// No dependencies.
package pdmx_pkg;

   typedef struct packed {
      logic        valid;
      logic [21:0] proc_id;
      logic [31:0] database_id;
      logic [63:0] xid;
   } slot_entry_type;

   localparam logic [2:0] STATUS_UNCHANGED = 3'd0;
   localparam logic [2:0] STATUS_UPDATED   = 3'd1;
   localparam logic [2:0] STATUS_NEW       = 3'd2;
   localparam logic [2:0] STATUS_REMOVED   = 3'd3;
   localparam logic [2:0] STATUS_UNKNOWN   = 3'd4;
   localparam logic [2:0] STATUS_FULL      = 3'd5;

   localparam logic KIND_UPDATE    = 1'b0;
   localparam logic KIND_TERMINATE = 1'b1;

endpackage

>>> src/per_database_min_xid_tracker.sv
// Per-database minimum xid tracker, top level.
// Depends on pdmx_pkg, pdmx_slot_mem and pdmx_ctrl.
//
// The req_ channel carries one report beat: an xid update (kind 0) or a
// process termination (kind 1). The rsp_ channel returns one or two beats
// per report, each with a status, a database and that database's minimum
// live xid; rsp_last_result marks the final beat of a report. The csr_ port
// writes the value reported for a database with no live transaction.
// Each report is worked through the slot memory one entry per cycle: a
// lookup scan, at most one update write, then a minimum scan per reported
// database. The next report is accepted only once the last is through;
// an unknown-process termination skips the minimum scan, and a changed
// database gives two beats and two minimum scans.
// A finished beat sits in an output register, so the next report is accepted
// while it waits. After reset a clearing pass frees every slot; req_stall
// stays high during it. If the receiver stalls, the block holds its beat and,
// once a second beat or the next report's beat is ready, waits for the output
// register to empty before going on.
module per_database_min_xid_tracker
   import pdmx_pkg::*;
#(
   parameter int PROCESS_SLOTS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [63:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [21:0] req_process_id,
   input  logic [31:0] req_database_id,
   input  logic [63:0] req_transaction_id,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_affected_database,
   output logic [63:0] rsp_minimum_xid,
   output logic        rsp_last_result
);

   localparam int ADDR_W = $clog2(PROCESS_SLOTS);

   logic [63:0]        no_xid_ff;
   logic               mem_wr_en;
   logic [ADDR_W-1:0]  mem_wr_addr;
   slot_entry_type     mem_wr_data;
   logic [ADDR_W-1:0]  mem_rd_addr;
   slot_entry_type     mem_rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         no_xid_ff <= '1;
      end else if (csr_write_enable) begin
         no_xid_ff <= csr_write_data;
      end
   end

   pdmx_slot_mem #(
      .SLOTS  (PROCESS_SLOTS),
      .ADDR_W (ADDR_W)
   ) u_slot_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   pdmx_ctrl #(
      .SLOTS  (PROCESS_SLOTS),
      .ADDR_W (ADDR_W)
   ) u_ctrl (
      .clock                 (clock),
      .reset                 (reset),
      .no_xid_value          (no_xid_ff),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_kind              (req_kind),
      .req_process_id        (req_process_id),
      .req_database_id       (req_database_id),
      .req_transaction_id    (req_transaction_id),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_status            (rsp_status),
      .rsp_affected_database (rsp_affected_database),
      .rsp_minimum_xid       (rsp_minimum_xid),
      .rsp_last_result       (rsp_last_result),
      .mem_wr_en             (mem_wr_en),
      .mem_wr_addr           (mem_wr_addr),
      .mem_wr_data           (mem_wr_data),
      .mem_rd_addr           (mem_rd_addr),
      .mem_rd_data           (mem_rd_data)
   );

endmodule

>>> src/pdmx_slot_mem.sv
// Process slot table: one write port and one read port with registered read data.
// Uses slot_entry_type from pdmx_pkg.
module pdmx_slot_mem
   import pdmx_pkg::*;
#(
   parameter int SLOTS  = 64,
   parameter int ADDR_W = 6
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  slot_entry_type      wr_data,
   input  logic [ADDR_W-1:0]   rd_addr,
   output slot_entry_type      rd_data
);

   slot_entry_type mem [SLOTS];
   slot_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/pdmx_ctrl.sv
// Sequencer for the tracker: clearing pass, lookup scan, table update,
// minimum scans and the result output register. Uses pdmx_pkg.
module pdmx_ctrl
   import pdmx_pkg::*;
#(
   parameter int SLOTS  = 64,
   parameter int ADDR_W = 6
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [63:0]         no_xid_value,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_kind,
   input  logic [21:0]         req_process_id,
   input  logic [31:0]         req_database_id,
   input  logic [63:0]         req_transaction_id,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [2:0]          rsp_status,
   output logic [31:0]         rsp_affected_database,
   output logic [63:0]         rsp_minimum_xid,
   output logic                rsp_last_result,
   output logic                mem_wr_en,
   output logic [ADDR_W-1:0]   mem_wr_addr,
   output slot_entry_type      mem_wr_data,
   output logic [ADDR_W-1:0]   mem_rd_addr,
   input  slot_entry_type      mem_rd_data
);

   localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(SLOTS - 1);

   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_LOOKUP = 6'b000100,
      ST_DECIDE = 6'b001000,
      ST_MIN    = 6'b010000,
      ST_EMIT   = 6'b100000
   } state_type;

   state_type          state_ff, state_in;
   logic               issuing_ff, issuing_in;
   logic [ADDR_W-1:0]  scan_addr_ff, scan_addr_in;
   logic               rd_vld_ff, rd_vld_in;
   logic [ADDR_W-1:0]  rd_idx_ff, rd_idx_in;
   logic               found_ff, found_in;
   logic               free_found_ff, free_found_in;
   logic               second_ff, second_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               kind_ff, kind_in;
   logic [21:0]        pid_ff, pid_in;
   logic [31:0]        db_ff, db_in;
   logic [63:0]        xid_ff, xid_in;
   logic [ADDR_W-1:0]  found_idx_ff, found_idx_in;
   logic [ADDR_W-1:0]  free_idx_ff, free_idx_in;
   logic [31:0]        old_db_ff, old_db_in;
   logic [63:0]        old_xid_ff, old_xid_in;
   logic [31:0]        target_db_ff, target_db_in;
   logic [2:0]         status_ff, status_in;
   logic               acc_any_ff, acc_any_in;
   logic [63:0]        acc_min_ff, acc_min_in;
   logic [2:0]         rsp_status_ff, rsp_status_in;
   logic [31:0]        rsp_db_ff, rsp_db_in;
   logic [63:0]        rsp_min_ff, rsp_min_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               accept;
   logic               out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign mem_rd_addr = scan_addr_ff;

   always_comb begin
      state_in      = state_ff;
      issuing_in    = issuing_ff;
      scan_addr_in  = scan_addr_ff;
      rd_vld_in     = issuing_ff;
      rd_idx_in     = scan_addr_ff;
      found_in      = found_ff;
      free_found_in = free_found_ff;
      second_in     = second_ff;
      kind_in       = kind_ff;
      pid_in        = pid_ff;
      db_in         = db_ff;
      xid_in        = xid_ff;
      found_idx_in  = found_idx_ff;
      free_idx_in   = free_idx_ff;
      old_db_in     = old_db_ff;
      old_xid_in    = old_xid_ff;
      target_db_in  = target_db_ff;
      status_in     = status_ff;
      acc_any_in    = acc_any_ff;
      acc_min_in    = acc_min_ff;
      rsp_status_in = rsp_status_ff;
      rsp_db_in     = rsp_db_ff;
      rsp_min_in    = rsp_min_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = found_idx_ff;
      mem_wr_data   = '{valid: 1'b1, proc_id: pid_ff, database_id: db_ff, xid: xid_ff};

      if (issuing_ff) begin
         scan_addr_in = scan_addr_ff + 1'b1;
         if (scan_addr_ff == LAST_IDX) begin
            issuing_in = 1'b0;
         end
      end

      unique case (state_ff)
         ST_CLEAR: begin
            // Every slot is marked free once before the first item is taken.
            mem_wr_en    = 1'b1;
            mem_wr_addr  = scan_addr_ff;
            mem_wr_data  = '0;
            scan_addr_in = scan_addr_ff + 1'b1;
            if (scan_addr_ff == LAST_IDX) begin
               scan_addr_in = '0;
               state_in     = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               kind_in       = req_kind;
               pid_in        = req_process_id;
               db_in         = req_database_id;
               xid_in        = req_transaction_id;
               found_in      = 1'b0;
               free_found_in = 1'b0;
               second_in     = 1'b0;
               issuing_in    = 1'b1;
               scan_addr_in  = '0;
               state_in      = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (rd_vld_ff) begin
               if (mem_rd_data.valid && mem_rd_data.proc_id == pid_ff && !found_ff) begin
                  found_in     = 1'b1;
                  found_idx_in = rd_idx_ff;
                  old_db_in    = mem_rd_data.database_id;
                  old_xid_in   = mem_rd_data.xid;
               end
               if (!mem_rd_data.valid && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = rd_idx_ff;
               end
               if (rd_idx_ff == LAST_IDX) begin
                  state_in = ST_DECIDE;
               end
            end
         end
         ST_DECIDE: begin
            acc_any_in   = 1'b0;
            issuing_in   = 1'b1;
            scan_addr_in = '0;
            state_in     = ST_MIN;
            target_db_in = db_ff;
            if (kind_ff == KIND_TERMINATE) begin
               if (!found_ff) begin
                  // Unknown process: no scan, the result carries a zero database and minimum.
                  status_in    = STATUS_UNKNOWN;
                  target_db_in = '0;
                  acc_any_in   = 1'b1;
                  acc_min_in   = '0;
                  issuing_in   = 1'b0;
                  state_in     = ST_EMIT;
               end else begin
                  mem_wr_en    = 1'b1;
                  mem_wr_data  = '{valid: 1'b0, proc_id: pid_ff,
                                   database_id: old_db_ff, xid: old_xid_ff};
                  status_in    = STATUS_REMOVED;
                  target_db_in = old_db_ff;
               end
            end else if (found_ff) begin
               if (old_db_ff == db_ff && old_xid_ff == xid_ff) begin
                  status_in = STATUS_UNCHANGED;
               end else begin
                  mem_wr_en = 1'b1;
                  status_in = STATUS_UPDATED;
                  if (old_db_ff != db_ff) begin
                     // The old database is reported first, then the new one.
                     target_db_in = old_db_ff;
                     second_in    = 1'b1;
                  end
               end
            end else if (free_found_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = free_idx_ff;
               status_in   = STATUS_NEW;
            end else begin
               status_in = STATUS_FULL;
            end
         end
         ST_MIN: begin
            if (rd_vld_ff) begin
               if (mem_rd_data.valid && mem_rd_data.database_id == target_db_ff) begin
                  acc_any_in = 1'b1;
                  if (!acc_any_ff || mem_rd_data.xid < acc_min_ff) begin
                     acc_min_in = mem_rd_data.xid;
                  end
               end
               if (rd_idx_ff == LAST_IDX) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_db_in     = target_db_ff;
               rsp_min_in    = acc_any_ff ? acc_min_ff : no_xid_value;
               rsp_last_in   = !second_ff;
               if (second_ff) begin
                  second_in    = 1'b0;
                  target_db_in = db_ff;
                  acc_any_in   = 1'b0;
                  issuing_in   = 1'b1;
                  scan_addr_in = '0;
                  state_in     = ST_MIN;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         issuing_ff    <= 1'b0;
         scan_addr_ff  <= '0;
         rd_vld_ff     <= 1'b0;
         found_ff      <= 1'b0;
         free_found_ff <= 1'b0;
         second_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         issuing_ff    <= issuing_in;
         scan_addr_ff  <= scan_addr_in;
         rd_vld_ff     <= rd_vld_in;
         found_ff      <= found_in;
         free_found_ff <= free_found_in;
         second_ff     <= second_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff     <= rd_idx_in;
      kind_ff       <= kind_in;
      pid_ff        <= pid_in;
      db_ff         <= db_in;
      xid_ff        <= xid_in;
      found_idx_ff  <= found_idx_in;
      free_idx_ff   <= free_idx_in;
      old_db_ff     <= old_db_in;
      old_xid_ff    <= old_xid_in;
      target_db_ff  <= target_db_in;
      status_ff     <= status_in;
      acc_any_ff    <= acc_any_in;
      acc_min_ff    <= acc_min_in;
      rsp_status_ff <= rsp_status_in;
      rsp_db_ff     <= rsp_db_in;
      rsp_min_ff    <= rsp_min_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_affected_database = rsp_db_ff;
   assign rsp_minimum_xid       = rsp_min_ff;
   assign rsp_last_result       = rsp_last_ff;

endmodule

>>> bench/tb_per_database_min_xid_tracker.sv
// Self-checking testbench for the per-database minimum xid tracker.
// Depends on pdmx_pkg and per_database_min_xid_tracker; keeps its own slot
// table to predict each beat not typed in a directed row and compares each beat field by field.
`timescale 1ns / 1ps

module tb_per_database_min_xid_tracker
   import pdmx_pkg::*;
();

   localparam int          SLOTS    = 64;
   localparam int          SETTLE   = 3 * SLOTS + 16;
   localparam int          POOL     = 80;
   localparam int          PHASES   = 6;
   localparam int          PER_PHASE = 235;
   localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic        kind;
      logic [21:0] pid;
      logic [31:0] db;
      logic [63:0] xid;
   } report_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] db;
      logic [63:0] minimum;
      logic        last;
   } min_result_type;

   // One directed beat; when fixed is set, the response is the one typed here.
   typedef struct packed {
      report_type     rpt;
      logic           fixed;
      min_result_type rsp;
   } directed_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [63:0] csr_write_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_kind = KIND_UPDATE;
   logic [21:0] req_process_id = '0;
   logic [31:0] req_database_id = '0;
   logic [63:0] req_transaction_id = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_affected_database;
   logic [63:0] rsp_minimum_xid;
   logic        rsp_last_result;

   // Shadow slot table and register.
   bit          slot_live[SLOTS];
   logic [21:0] slot_pid[SLOTS];
   logic [31:0] slot_db[SLOTS];
   logic [63:0] slot_xid[SLOTS];
   logic [63:0] empty_xid = ALL_ONES;

   min_result_type pending_minimums[$];
   min_result_type want;
   int          errors = 0;
   bit          tx_steady = 1'b0;
   bit          rx_steady = 1'b0;

   logic [21:0] pid_pool[POOL];
   logic [31:0] db_pool[6];

   per_database_min_xid_tracker #(.PROCESS_SLOTS(SLOTS)) u_top (
      .clock                 (clock),
      .reset                 (reset),
      .csr_write_enable      (csr_write_enable),
      .csr_write_data        (csr_write_data),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_kind              (req_kind),
      .req_process_id        (req_process_id),
      .req_database_id       (req_database_id),
      .req_transaction_id    (req_transaction_id),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_status            (rsp_status),
      .rsp_affected_database (rsp_affected_database),
      .rsp_minimum_xid       (rsp_minimum_xid),
      .rsp_last_result       (rsp_last_result)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_stall <= rx_steady ? 1'b0 : ($urandom_range(0, 99) < 24);
   end

   function automatic int find_slot(input logic [21:0] pid);
      for (int i = 0; i < SLOTS; i++)
         if (slot_live[i] && slot_pid[i] == pid) return i;
      return -1;
   endfunction

   function automatic logic [63:0] db_floor(input logic [31:0] db);
      logic        found;
      logic [63:0] low;
      found = 1'b0;
      low   = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (slot_live[i] && slot_db[i] == db) begin
            if (!found || slot_xid[i] < low) low = slot_xid[i];
            found = 1'b1;
         end
      end
      return found ? low : empty_xid;
   endfunction

   // Applies one report to the shadow table and returns the number of beats.
   function automatic int apply_report(input report_type r, output min_result_type first,
                                       output min_result_type second);
      int          s;
      logic [31:0] old_db;
      s      = find_slot(r.pid);
      first  = '0;
      second = '0;
      if (r.kind == KIND_TERMINATE) begin
         if (s < 0) begin
            first = '{STATUS_UNKNOWN, 32'd0, 64'd0, 1'b1};
            return 1;
         end
         old_db       = slot_db[s];
         slot_live[s] = 1'b0;
         first = '{STATUS_REMOVED, old_db, db_floor(old_db), 1'b1};
         return 1;
      end
      if (s >= 0) begin
         old_db = slot_db[s];
         if (old_db == r.db && slot_xid[s] == r.xid) begin
            first = '{STATUS_UNCHANGED, r.db, db_floor(r.db), 1'b1};
            return 1;
         end
         slot_db[s]  = r.db;
         slot_xid[s] = r.xid;
         if (old_db != r.db) begin
            first  = '{STATUS_UPDATED, old_db, db_floor(old_db), 1'b0};
            second = '{STATUS_UPDATED, r.db, db_floor(r.db), 1'b1};
            return 2;
         end
         first = '{STATUS_UPDATED, r.db, db_floor(r.db), 1'b1};
         return 1;
      end
      for (int i = SLOTS - 1; i >= 0; i--)
         if (!slot_live[i]) s = i;
      if (s < 0) begin
         first = '{STATUS_FULL, r.db, db_floor(r.db), 1'b1};
         return 1;
      end
      slot_live[s] = 1'b1;
      slot_pid[s]  = r.pid;
      slot_db[s]   = r.db;
      slot_xid[s]  = r.xid;
      first = '{STATUS_NEW, r.db, db_floor(r.db), 1'b1};
      return 1;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic drive_report(input report_type r, input logic fixed,
                               input min_result_type rsp);
      min_result_type first, second;
      int             beats;
      while (!tx_steady && $urandom_range(0, 99) < 24) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_kind           <= r.kind;
      req_process_id     <= r.pid;
      req_database_id    <= r.db;
      req_transaction_id <= r.xid;
      do @(posedge clock); while (req_stall);
      beats = apply_report(r, first, second);
      if (fixed) begin
         pending_minimums = {pending_minimums, rsp};
      end else begin
         pending_minimums = {pending_minimums, first};
         if (beats == 2) pending_minimums = {pending_minimums, second};
      end
      @(negedge clock);
   endtask

   // Waits for every expected beat, then lets the block finish its scans.
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_minimums.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_minimums.size() == 0) begin
            $error("response beat with nothing expected: status %0d db %h min %h",
                   rsp_status, rsp_affected_database, rsp_minimum_xid);
            errors++;
         end else begin
            want = pending_minimums.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               errors++;
            end
            if (rsp_affected_database !== want.db) begin
               $error("affected_database: expected %h, got %h", want.db,
                      rsp_affected_database);
               errors++;
            end
            if (rsp_minimum_xid !== want.minimum) begin
               $error("minimum_xid: expected %h, got %h", want.minimum, rsp_minimum_xid);
               errors++;
            end
            if (rsp_last_result !== want.last) begin
               $error("last_result: expected %0d, got %0d", want.last, rsp_last_result);
               errors++;
            end
         end
      end
   end

   initial begin
      #25_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      directed_row_type rows[16];
      report_type       r;
      int               slot, pick, roll, pool_n, term_pct;
      logic [63:0]      setting;

      // Empty value is still at its reset value during the directed rows.
      rows = '{
         '{'{KIND_TERMINATE, 22'd5, 32'd0, 64'd0}, 1'b1,
           '{STATUS_UNKNOWN, 32'd0, 64'd0, 1'b1}},
         '{'{KIND_UPDATE, 22'd0, 32'd0, 64'd0}, 1'b1,
           '{STATUS_NEW, 32'd0, 64'd0, 1'b1}},
         '{'{KIND_UPDATE, 22'h3FFFFF, 32'hFFFF_FFFF, ALL_ONES}, 1'b1,
           '{STATUS_NEW, 32'hFFFF_FFFF, ALL_ONES, 1'b1}},
         '{'{KIND_UPDATE, 22'd0, 32'd0, 64'd0}, 1'b1,
           '{STATUS_UNCHANGED, 32'd0, 64'd0, 1'b1}},
         '{'{KIND_UPDATE, 22'd1, 32'd0, 64'd100}, 1'b1,
           '{STATUS_NEW, 32'd0, 64'd0, 1'b1}},
         '{'{KIND_UPDATE, 22'd0, 32'd0, 64'd200}, 1'b0, '0},
         '{'{KIND_UPDATE, 22'd0, 32'd7, 64'd50}, 1'b0, '0},
         '{'{KIND_UPDATE, 22'd2, 32'd7, 64'd0}, 1'b1,
           '{STATUS_NEW, 32'd7, 64'd0, 1'b1}},
         '{'{KIND_TERMINATE, 22'd1, 32'hDEAD_BEEF, 64'h1234_5678_9ABC_DEF0}, 1'b1,
           '{STATUS_REMOVED, 32'd0, ALL_ONES, 1'b1}},
         '{'{KIND_TERMINATE, 22'd1, 32'd0, 64'd0}, 1'b1,
           '{STATUS_UNKNOWN, 32'd0, 64'd0, 1'b1}},
         '{'{KIND_UPDATE, 22'h3FFFFF, 32'hFFFF_FFFF, 64'd0}, 1'b0, '0},
         '{'{KIND_UPDATE, 22'h3FFFFF, 32'd0, 64'h8000_0000_0000_0000}, 1'b0, '0},
         '{'{KIND_TERMINATE, 22'h3FFFFF, ALL_ONES[31:0], ALL_ONES}, 1'b1,
           '{STATUS_REMOVED, 32'd0, ALL_ONES, 1'b1}},
         '{'{KIND_TERMINATE, 22'd2, 32'd0, 64'd0}, 1'b0, '0},
         '{'{KIND_TERMINATE, 22'd0, 32'd0, 64'd0}, 1'b1,
           '{STATUS_REMOVED, 32'd7, ALL_ONES, 1'b1}},
         '{'{KIND_TERMINATE, 22'd0, 32'd0, 64'd0}, 1'b1,
           '{STATUS_UNKNOWN, 32'd0, 64'd0, 1'b1}}
      };

      pid_pool[0] = 22'd0;
      pid_pool[1] = 22'h3FFFFF;
      for (int i = 2; i < POOL; i++) pid_pool[i] = 22'($urandom_range(0, 22'h3FFFFF));
      db_pool[0] = 32'd0;
      db_pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < 6; i++) db_pool[i] = $urandom;

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      foreach (rows[i]) drive_report(rows[i].rpt, rows[i].fixed, rows[i].rsp);

      for (int phase = 0; phase < PHASES; phase++) begin
         settle();
         case (phase)
            0: setting = 64'd0;
            1: setting = ALL_ONES;
            3: setting = 64'd500;
            5: setting = ALL_ONES;
            default: setting = {$urandom, $urandom};
         endcase
         csr_write_enable <= 1'b1;
         csr_write_data   <= setting;
         @(posedge clock);
         empty_xid = setting;
         @(negedge clock);
         csr_write_enable <= 1'b0;

         // Phase 2 runs with both sides never idling.
         tx_steady = (phase == 2);
         rx_steady = (phase == 2);
         // Large pools overfill the table; small ones revisit the same processes.
         case (phase)
            0: begin pool_n = POOL; term_pct = 10; end
            1: begin pool_n = 24;   term_pct = 30; end
            2: begin pool_n = POOL; term_pct = 12; end
            3: begin pool_n = 8;    term_pct = 25; end
            4: begin pool_n = POOL; term_pct = 15; end
            default: begin pool_n = 48; term_pct = 45; end
         endcase

         for (int n = 0; n < PER_PHASE; n++) begin
            roll = $urandom_range(0, 10);
            r.xid = (roll < 5) ? 64'($urandom_range(0, 1000)) :
                    (roll < 9) ? {$urandom, $urandom} :
                    (roll == 9) ? 64'd0 : ALL_ONES;
            r.db  = ($urandom_range(0, 99) < 85) ? db_pool[$urandom_range(0, 5)] : $urandom;
            r.pid = pid_pool[$urandom_range(0, pool_n - 1)];
            if ($urandom_range(0, 99) < term_pct) begin
               r.kind = KIND_TERMINATE;
               if ($urandom_range(0, 19) == 0) r.pid = 22'($urandom_range(0, 22'h3FFFFF));
            end else begin
               r.kind = KIND_UPDATE;
               slot   = find_slot(r.pid);
               pick   = $urandom_range(0, 99);
               if (slot >= 0 && pick < 40) begin
                  r.db  = slot_db[slot];
                  r.xid = slot_xid[slot];
               end else if (slot >= 0 && pick < 70) begin
                  r.db = slot_db[slot];
               end
            end
            drive_report(r, 1'b0, '0);
         end
      end

      tx_steady = 1'b0;
      rx_steady = 1'b0;
      settle();
      if (errors == 0 && pending_minimums.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
